// ===== hdl/buffered_uart_ring_fifos_top_macros.svh =====
// assertion macros used by the rtl back end (bufu_back)
`ifndef BUFFERED_UART_RING_FIFOS_TOP_MACROS_SVH
`define BUFFERED_UART_RING_FIFOS_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BUFU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// expression never holds
`define BUFU_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== hdl/bufu_pkg.sv =====
`timescale 1ns / 1ps
package bufu_pkg;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_RX     = 2'd2,
    KIND_TXDONE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic       line_out_valid;
    logic [7:0] line_out_byte;
    logic       rx_nonempty;
    logic       overflow_error;
    logic       tx_busy;
    logic       tx_done;
  } result_t;

  typedef struct packed {
    logic       rvalid;
    logic       accepted;
    logic       lvalid;
    logic       bypass;
    logic [7:0] data;
    logic       nonempty;
  } pend_t;

  typedef enum logic {
    BS_IDLE  = 1'b0,
    BS_FETCH = 1'b1
  } back_state_e;

endpackage

// ===== hdl/bufu_ram.sv =====
`timescale 1ns / 1ps
module bufu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bufu_front.sv =====
`timescale 1ns / 1ps
module bufu_front import bufu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_i,
  output logic       op_valid_o,
  output op_t        op_o,
  input  logic       op_ready_i
);

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  op_t        cls;
  logic       push, pop;

  // data only matters for writes and received bytes
  always_comb begin
    cls.kind = kind_e'(kind_i);
    unique case (kind_e'(kind_i))
      KIND_WRITE, KIND_RX: cls.data = data_i;
      KIND_READ, KIND_TXDONE: cls.data = 8'h00;
      default: cls.data = 8'h00;
    endcase
  end

  assign in_ready_o = (count_q != 2'd2);
  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hdl/bufu_back.sv =====
`timescale 1ns / 1ps
`include "buffered_uart_ring_fifos_top_macros.svh"
module bufu_back import bufu_pkg::*; #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    op_valid_i,
  input  op_t     op_i,
  output logic    op_ready_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  localparam int unsigned RX_PW = $clog2(RX_DEPTH);
  localparam int unsigned TX_PW = $clog2(TX_DEPTH);
  localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
  localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

  back_state_e      state_q, state_d;
  logic [RX_PW-1:0] rx_w_q, rx_w_d, rx_r_q, rx_r_d, rx_w_inc, rx_r_inc;
  logic [TX_PW-1:0] tx_w_q, tx_w_d, tx_r_q, tx_r_d, tx_w_inc, tx_r_inc;
  logic             ovf_q, ovf_d, busy_q, busy_d, cmpl_q, cmpl_d;
  pend_t            pend_q, pend_d;
  result_t          res_q, res_d;
  logic             res_valid_q, res_valid_d;
  logic             take;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [RX_PW-1:0] rx_waddr, rx_raddr;
  logic [TX_PW-1:0] tx_waddr, tx_raddr;
  logic [7:0]       rx_rdata, tx_rdata;

  assign rx_w_inc = (rx_w_q == RX_LAST) ? '0 : rx_w_q + 1'b1;
  assign rx_r_inc = (rx_r_q == RX_LAST) ? '0 : rx_r_q + 1'b1;
  assign tx_w_inc = (tx_w_q == TX_LAST) ? '0 : tx_w_q + 1'b1;
  assign tx_r_inc = (tx_r_q == TX_LAST) ? '0 : tx_r_q + 1'b1;

  bufu_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (op_i.data),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  bufu_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (op_i.data),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  always_comb begin
    state_d     = state_q;
    rx_w_d      = rx_w_q;
    rx_r_d      = rx_r_q;
    tx_w_d      = tx_w_q;
    tx_r_d      = tx_r_q;
    ovf_d       = ovf_q;
    busy_d      = busy_q;
    cmpl_d      = cmpl_q;
    pend_d      = pend_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    take        = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_waddr    = rx_w_inc;
    rx_raddr    = rx_r_inc;
    tx_waddr    = tx_w_inc;
    tx_raddr    = tx_r_inc;

    unique case (state_q)
      BS_IDLE: begin
        if (op_valid_i && (!res_valid_q || res_ready_i)) begin
          take        = 1'b1;
          state_d     = BS_FETCH;
          pend_d      = '0;
          pend_d.data = op_i.data;
          unique case (op_i.kind)
            KIND_READ: begin
              if (rx_w_q != rx_r_q) begin
                rx_r_d        = rx_r_inc;
                rx_re         = 1'b1;
                pend_d.rvalid = 1'b1;
              end
            end
            KIND_WRITE: begin
              if (tx_w_inc != tx_r_q) begin
                tx_we           = 1'b1;
                tx_w_d          = tx_w_inc;
                pend_d.accepted = 1'b1;
                if (!busy_q) begin
                  busy_d        = 1'b1;
                  cmpl_d        = 1'b0;
                  tx_r_d        = tx_r_inc;
                  tx_re         = 1'b1;
                  pend_d.lvalid = 1'b1;
                  pend_d.bypass = (tx_r_inc == tx_w_inc);
                end
              end
            end
            KIND_RX: begin
              rx_w_d = rx_w_inc;
              rx_we  = 1'b1;
              if (rx_w_inc == rx_r_q) begin
                ovf_d = 1'b1;
              end
            end
            KIND_TXDONE: begin
              if (tx_w_q != tx_r_q) begin
                tx_r_d        = tx_r_inc;
                tx_re         = 1'b1;
                pend_d.lvalid = 1'b1;
              end else begin
                busy_d = 1'b0;
                cmpl_d = 1'b1;
              end
            end
            default: ;
          endcase
          pend_d.nonempty = (rx_w_d != rx_r_d);
        end
      end
      BS_FETCH: begin
        state_d              = BS_IDLE;
        res_valid_d          = 1'b1;
        res_d.read_valid     = pend_q.rvalid;
        res_d.read_byte      = pend_q.rvalid ? rx_rdata : 8'h00;
        res_d.write_accepted = pend_q.accepted;
        res_d.line_out_valid = pend_q.lvalid;
        res_d.line_out_byte  = !pend_q.lvalid ? 8'h00 :
                               (pend_q.bypass ? pend_q.data : tx_rdata);
        res_d.rx_nonempty    = pend_q.nonempty;
        res_d.overflow_error = ovf_q;
        res_d.tx_busy        = busy_q;
        res_d.tx_done        = cmpl_q;
      end
      default: ;
    endcase
  end

  assign op_ready_o  = take;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      rx_w_q      <= '0;
      rx_r_q      <= '0;
      tx_w_q      <= '0;
      tx_r_q      <= '0;
      ovf_q       <= 1'b0;
      busy_q      <= 1'b0;
      cmpl_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rx_w_q      <= rx_w_d;
      rx_r_q      <= rx_r_d;
      tx_w_q      <= tx_w_d;
      tx_r_q      <= tx_r_d;
      ovf_q       <= ovf_d;
      busy_q      <= busy_d;
      cmpl_q      <= cmpl_d;
      res_valid_q <= res_valid_d;
    end
  end

  `BUFU_ASSERT_IMPL(a_fetch_out_free, state_q == BS_FETCH, !res_valid_q)
  `BUFU_ASSERT_NEVER(a_busy_and_done, busy_q && cmpl_q)
  `BUFU_ASSERT_IMPL(a_ovf_from_rx, $rose(ovf_q), $past(take && (op_i.kind == KIND_RX)))
  `BUFU_ASSERT_IMPL(a_idle_tx_empty, !busy_q, tx_w_q == tx_r_q)

endmodule

// ===== hdl/buffered_uart_ring_fifos_top.sv =====
`timescale 1ns / 1ps
// a beat is queued, then taken by the back end with a ram read, and its result is registered
// the back end takes a new event only after the last result, due to the registered fifo ram read
// a 2-beat queue keeps input beats flowing while a finished result waits at the output
// reset: rst_ni async active low clears all pointers, flags and the queue; fifo rams are not cleared
module buffered_uart_ring_fifos_top import bufu_pkg::*; #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       write_accepted_o,
  output logic       line_out_valid_o,
  output logic [7:0] line_out_byte_o,
  output logic       rx_nonempty_o,
  output logic       overflow_error_o,
  output logic       tx_busy_o,
  output logic       tx_done_o
);

  logic    op_valid, op_ready;
  op_t     op;
  result_t res;

  bufu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .data_i     (data_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_ready_i (op_ready)
  );

  bufu_back #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_ready_o  (op_ready),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .res_ready_i (out_ready_i)
  );

  assign read_valid_o     = res.read_valid;
  assign read_byte_o      = res.read_byte;
  assign write_accepted_o = res.write_accepted;
  assign line_out_valid_o = res.line_out_valid;
  assign line_out_byte_o  = res.line_out_byte;
  assign rx_nonempty_o    = res.rx_nonempty;
  assign overflow_error_o = res.overflow_error;
  assign tx_busy_o        = res.tx_busy;
  assign tx_done_o        = res.tx_done;

endmodule

// ===== tb/sv/tb_buffered_uart_ring_fifos_top.sv =====
`timescale 1ns / 1ps
module tb_buffered_uart_ring_fifos_top;
  import bufu_pkg::*;

  localparam int unsigned RXD = 16;
  localparam int unsigned TXD = 16;
  localparam int unsigned N_RANDOM = 800;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned CYCLE_LIMIT = 400000;

  class uart_ring_model;
    logic [7:0] rx_mem[RXD];
    logic [7:0] tx_mem[TXD];
    int unsigned rx_wr, rx_rd, tx_wr, tx_rd;
    bit overrun, busy, complete;
    result_t pending_results[$];
    int unsigned errors, n_events, n_results;
    int unsigned n_line, n_refused, n_empty_reads, n_overruns;

    function new();
      rx_wr = 0;
      rx_rd = 0;
      tx_wr = 0;
      tx_rd = 0;
      overrun = 0;
      busy = 0;
      complete = 0;
      errors = 0;
      n_events = 0;
      n_results = 0;
      n_line = 0;
      n_refused = 0;
      n_empty_reads = 0;
      n_overruns = 0;
    endfunction

    function int unsigned bump(int unsigned p, int unsigned depth);
      return (p + 1 >= depth) ? 0 : p + 1;
    endfunction

    function void note_event(kind_e k, logic [7:0] d);
      result_t r;
      int unsigned nxt;
      r = '0;
      n_events++;
      case (k)
        KIND_READ: begin
          if (rx_wr != rx_rd) begin
            rx_rd = bump(rx_rd, RXD);
            r.read_valid = 1'b1;
            r.read_byte = rx_mem[rx_rd];
          end else begin
            n_empty_reads++;
          end
        end
        KIND_WRITE: begin
          nxt = bump(tx_wr, TXD);
          if (nxt != tx_rd) begin
            tx_mem[nxt] = d;
            tx_wr = nxt;
            r.write_accepted = 1'b1;
            if (!busy) begin
              busy = 1'b1;
              complete = 1'b0;
              tx_rd = bump(tx_rd, TXD);
              r.line_out_valid = 1'b1;
              r.line_out_byte = tx_mem[tx_rd];
            end
          end else begin
            n_refused++;
          end
        end
        KIND_RX: begin
          rx_wr = bump(rx_wr, RXD);
          if (rx_wr == rx_rd) begin
            overrun = 1'b1;
            n_overruns++;
          end
          rx_mem[rx_wr] = d;
        end
        default: begin
          if (tx_wr != tx_rd) begin
            tx_rd = bump(tx_rd, TXD);
            r.line_out_valid = 1'b1;
            r.line_out_byte = tx_mem[tx_rd];
          end else begin
            busy = 1'b0;
            complete = 1'b1;
          end
        end
      endcase
      if (r.line_out_valid) n_line++;
      r.rx_nonempty = (rx_wr != rx_rd);
      r.overflow_error = overrun;
      r.tx_busy = busy;
      r.tx_done = complete;
      pending_results.push_back(r);
    endfunction

    task report(string field, int unsigned got, int unsigned want);
      $display("%0t: result %0d, %s: got %0h, want %0h", $time, n_results, field, got, want);
      errors++;
    endtask

    task cmp(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) report(field, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      n_results++;
      if (pending_results.size() == 0) begin
        report("beat with nothing pending", got, 0);
      end else begin
        want = pending_results.pop_front();
        cmp("read_valid", got.read_valid, want.read_valid);
        cmp("read_byte", got.read_byte, want.read_byte);
        cmp("write_accepted", got.write_accepted, want.write_accepted);
        cmp("line_out_valid", got.line_out_valid, want.line_out_valid);
        cmp("line_out_byte", got.line_out_byte, want.line_out_byte);
        cmp("rx_nonempty", got.rx_nonempty, want.rx_nonempty);
        cmp("overflow_error", got.overflow_error, want.overflow_error);
        cmp("tx_busy", got.tx_busy, want.tx_busy);
        cmp("tx_done", got.tx_done, want.tx_done);
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] kind_i;
  logic [7:0] data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       read_valid_o;
  logic [7:0] read_byte_o;
  logic       write_accepted_o;
  logic       line_out_valid_o;
  logic [7:0] line_out_byte_o;
  logic       rx_nonempty_o;
  logic       overflow_error_o;
  logic       tx_busy_o;
  logic       tx_done_o;

  result_t        got_beat;
  uart_ring_model sb;
  bit             stall_en;
  bit             idle_en;
  int unsigned    cycles;
  int unsigned    n_sent;

  buffered_uart_ring_fifos_top #(
    .RX_DEPTH(RXD),
    .TX_DEPTH(TXD)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .data_i          (data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_valid_o    (read_valid_o),
    .read_byte_o     (read_byte_o),
    .write_accepted_o(write_accepted_o),
    .line_out_valid_o(line_out_valid_o),
    .line_out_byte_o (line_out_byte_o),
    .rx_nonempty_o   (rx_nonempty_o),
    .overflow_error_o(overflow_error_o),
    .tx_busy_o       (tx_busy_o),
    .tx_done_o       (tx_done_o)
  );

  assign got_beat = {read_valid_o, read_byte_o, write_accepted_o, line_out_valid_o,
                     line_out_byte_o, rx_nonempty_o, overflow_error_o, tx_busy_o, tx_done_o};

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_event(kind_e'(kind_i), data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(got_beat);
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if (stall_en && $urandom_range(0, 9) == 0) begin
        out_ready_i = 1'b0;
        hold = $urandom_range(1, 17) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task send_event(kind_e k, logic [7:0] d);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 17)) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = k;
    data_i = d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
  endtask

  task wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic kind_e pick_kind(int unsigned wr, int unsigned ww, int unsigned wx,
                                      int unsigned wt);
    int unsigned roll;
    roll = $urandom_range(0, wr + ww + wx + wt - 1);
    if (roll < wr) return KIND_READ;
    if (roll < wr + ww) return KIND_WRITE;
    if (roll < wr + ww + wx) return KIND_RX;
    return KIND_TXDONE;
  endfunction

  initial begin
    int unsigned seg_len;
    int unsigned profile;
    int unsigned target;
    kind_e k;
    sb = new();
    cycles = 0;
    n_sent = 0;
    stall_en = 0;
    idle_en = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_READ;
    data_i = 8'h00;
    out_ready_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty read, idle done and write, busy writes, drain, rx, reads, drain
    send_event(KIND_READ, 8'hff);
    send_event(KIND_TXDONE, 8'h00);
    send_event(KIND_WRITE, 8'h00);
    send_event(KIND_WRITE, 8'hff);
    send_event(KIND_WRITE, 8'h80);
    send_event(KIND_TXDONE, 8'h55);
    send_event(KIND_TXDONE, 8'haa);
    send_event(KIND_TXDONE, 8'h01);
    send_event(KIND_RX, 8'h00);
    send_event(KIND_RX, 8'hff);
    send_event(KIND_RX, 8'h01);
    send_event(KIND_READ, 8'h00);
    send_event(KIND_READ, 8'h00);
    send_event(KIND_READ, 8'h00);
    send_event(KIND_READ, 8'h00);
    send_event(KIND_WRITE, 8'h7f);
    send_event(KIND_TXDONE, 8'hfe);
    send_event(KIND_TXDONE, 8'h00);
    wait_drained();

    target = n_sent + N_RANDOM;
    while (n_sent < target) begin
      seg_len = $urandom_range(20, 60);
      profile = $urandom_range(0, 3);
      stall_en = (target - n_sent > QUIET_TAIL) && ($urandom_range(0, 2) != 0);
      idle_en = (target - n_sent > QUIET_TAIL) && ($urandom_range(0, 2) != 0);
      repeat (seg_len) begin
        case (profile)
          0: k = pick_kind(1, 1, 1, 1);
          1: k = pick_kind(1, 0, 6, 1);
          2: k = pick_kind(1, 6, 1, 1);
          default: k = pick_kind(4, 1, 0, 4);
        endcase
        send_event(k, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    stall_en = 0;
    idle_en = 0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("%0d events, %0d results: %0d line bytes, %0d refused writes, %0d empty reads",
             sb.n_events, sb.n_results, sb.n_line, sb.n_refused, sb.n_empty_reads);
    $display("%0d receive overruns, both fifos taken through full and empty",
             sb.n_overruns);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
